// ----- sv/pdtk_pkg.sv -----
// Package: shared types and constants for the PPS disciplined timestamp keeper.
`default_nettype none
package pdtk_pkg;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned UNIX_W = 48;
	localparam int unsigned SYS_W = 32;
	localparam int unsigned LOCAL_W = 32;
	localparam int unsigned SRC_W = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 48;

	localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PPS   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_GPS   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SYNC  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;

	localparam logic [SRC_W-1:0] SRC_LOCAL   = 2'd0;
	localparam logic [SRC_W-1:0] SRC_GPS     = 2'd1;
	localparam logic [SRC_W-1:0] SRC_NETWORK = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NTP_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID  = 1'd1;

	localparam logic [LOCAL_W-1:0] PPS_MIN_GAP   = 32'd900;
	localparam logic [LOCAL_W-1:0] PPS_MAX_GAP   = 32'd1100;
	localparam logic [UNIX_W-1:0]  MS_PER_S      = 48'd1000;
	localparam logic [SYS_W-1:0]   SYS_PLAUSIBLE = 32'd100000;
	localparam logic [UNIX_W-1:0]  MIN_VALID_RESET = 48'd1763651027000;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [UNIX_W-1:0] unix_ms;
		logic [SYS_W-1:0]  system_seconds;
	} item_t;

	typedef struct packed {
		logic [UNIX_W-1:0] timestamp_ms;
		logic [SRC_W-1:0]  time_source;
		logic              synced;
		logic              accepted;
	} result_t;

	typedef struct packed {
		logic              ntp_enable;
		logic [UNIX_W-1:0] valid_floor_ms;
	} cfg_t;
endpackage
`default_nettype wire

// ----- sv/pdtk_if.sv -----
// Interfaces: item, result and configuration write channels.
`default_nettype none
interface pdtk_item_if;
	logic                       valid;
	logic                       ready;
	logic [pdtk_pkg::KIND_W-1:0] kind;
	logic [pdtk_pkg::UNIX_W-1:0] unix_ms;
	logic [pdtk_pkg::SYS_W-1:0]  system_seconds;
	modport source (output valid, output kind, output unix_ms, output system_seconds,
		input ready);
	modport sink (input valid, input kind, input unix_ms, input system_seconds,
		output ready);
endinterface

interface pdtk_result_if;
	logic                       valid;
	logic                       ready;
	logic [pdtk_pkg::UNIX_W-1:0] timestamp_ms;
	logic [pdtk_pkg::SRC_W-1:0]  time_source;
	logic                       synced;
	logic                       accepted;
	modport source (output valid, output timestamp_ms, output time_source, output synced,
		output accepted, input ready);
	modport sink (input valid, input timestamp_ms, input time_source, input synced,
		input accepted, output ready);
endinterface

interface pdtk_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pdtk_pkg::CFG_IDX_W-1:0]  index;
	logic [pdtk_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/pdtk_cfg_regs.sv -----
// Configuration registers: NTP fallback enable and minimum valid Unix time.
`default_nettype none
module pdtk_cfg_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pdtk_cfg_if.sink         cfg,
	output pdtk_pkg::cfg_t   cfg_regs
);
	import pdtk_pkg::*;

	logic              ntp_enable_q;
	logic [UNIX_W-1:0] min_valid_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ntp_enable_q <= 1'b0;
			min_valid_q  <= MIN_VALID_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_NTP_ENABLE: ntp_enable_q <= cfg.data[0];
				REG_MIN_VALID:  min_valid_q  <= cfg.data[UNIX_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_regs.ntp_enable     = ntp_enable_q;
	assign cfg_regs.valid_floor_ms = min_valid_q;
endmodule
`default_nettype wire

// ----- sv/pdtk_core.sv -----
// Time keeping core: state registers and a combinational update per item.
`default_nettype none
module pdtk_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire pdtk_pkg::item_t  item,
	input  wire pdtk_pkg::cfg_t   cfg_regs,
	output pdtk_pkg::result_t     result
);
	import pdtk_pkg::*;

	logic [LOCAL_W-1:0] local_q, base_local_q, last_pps_q;
	logic [UNIX_W-1:0]  base_unix_q;
	logic               base_valid_q;
	logic [SRC_W-1:0]   source_q;

	logic [LOCAL_W-1:0] local_d, base_local_d, last_pps_d;
	logic [UNIX_W-1:0]  base_unix_d;
	logic               base_valid_d;
	logic [SRC_W-1:0]   source_d;

	logic               usable;
	logic [LOCAL_W-1:0] base_gap, pps_gap;
	logic [UNIX_W-1:0]  sys_ext, net_ms, ts;
	logic               sys_plausible, acc;

	assign usable        = base_valid_q && (base_unix_q >= cfg_regs.valid_floor_ms);
	assign base_gap      = local_q - base_local_q;
	assign pps_gap       = local_q - last_pps_q;
	assign sys_ext       = {{(UNIX_W-SYS_W){1'b0}}, item.system_seconds};
	assign net_ms        = (sys_ext << 10) - (sys_ext << 4) - (sys_ext << 3);
	assign sys_plausible = item.system_seconds > SYS_PLAUSIBLE;

	always_comb begin
		local_d      = local_q;
		base_local_d = base_local_q;
		last_pps_d   = last_pps_q;
		base_unix_d  = base_unix_q;
		base_valid_d = base_valid_q;
		source_d     = source_q;
		ts           = '0;
		acc          = 1'b0;
		case (item.kind)
			KIND_TICK: begin
				local_d = local_q + 1'b1;
			end
			KIND_PPS: begin
				last_pps_d = local_q;
				if (usable && base_gap > PPS_MIN_GAP && base_gap < PPS_MAX_GAP) begin
					base_unix_d  = base_unix_q + MS_PER_S;
					base_local_d = local_q;
				end
			end
			KIND_GPS: begin
				if (item.unix_ms != '0 && item.unix_ms >= cfg_regs.valid_floor_ms) begin
					base_unix_d  = item.unix_ms;
					base_local_d = (pps_gap < PPS_MIN_GAP) ? last_pps_q : local_q;
					base_valid_d = 1'b1;
					source_d     = SRC_GPS;
					acc          = 1'b1;
				end
			end
			KIND_SYNC: begin
				if (item.unix_ms >= cfg_regs.valid_floor_ms) begin
					base_unix_d  = item.unix_ms;
					base_local_d = local_q;
					base_valid_d = 1'b1;
					source_d     = SRC_NETWORK;
					acc          = 1'b1;
				end
			end
			KIND_QUERY: begin
				if (usable) begin
					ts = base_unix_q + {{(UNIX_W-LOCAL_W){1'b0}}, base_gap};
				end else if (cfg_regs.ntp_enable && sys_plausible) begin
					if (!base_valid_q && net_ms >= cfg_regs.valid_floor_ms) begin
						base_unix_d  = net_ms;
						base_local_d = local_q;
						base_valid_d = 1'b1;
						acc          = 1'b1;
					end
					source_d = SRC_NETWORK;
					ts       = net_ms;
				end else begin
					source_d = SRC_LOCAL;
					ts       = {{(UNIX_W-LOCAL_W){1'b0}}, local_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q      <= '0;
			base_local_q <= '0;
			last_pps_q   <= '0;
			base_unix_q  <= '0;
			base_valid_q <= 1'b0;
			source_q     <= SRC_LOCAL;
		end else if (fire) begin
			local_q      <= local_d;
			base_local_q <= base_local_d;
			last_pps_q   <= last_pps_d;
			base_unix_q  <= base_unix_d;
			base_valid_q <= base_valid_d;
			source_q     <= source_d;
		end
	end

	assign result.timestamp_ms = ts;
	assign result.time_source  = source_d;
	assign result.synced       = (base_valid_d &&
		(base_unix_d >= cfg_regs.valid_floor_ms)) || sys_plausible;
	assign result.accepted     = acc;

`ifndef ASSERT_OFF
	a_tick_advance: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.kind == KIND_TICK |=> local_q == $past(local_q) + 1'b1)
		else $error("tick did not advance local count");
	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		base_valid_q |=> base_valid_q)
		else $error("base valid flag dropped");
	a_accept_sets_base: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.accepted |=> base_valid_q && source_q != SRC_LOCAL)
		else $error("accepted transaction did not install a base");
`endif
endmodule
`default_nettype wire

// ----- sv/pps_disciplined_timestamp_keeper.sv -----
// Top level: input register, time keeping core and result register.
// Path: an input transaction passes the input register and then the result register to result valid.
// Throughput: one item per cycle while result.ready is high; the combinational core update sets this rate.
// While a result waits, hold one item in the input register and stall the input.
// Reset (arst_n low) clears all time state and valid flags and restores configuration defaults.
`default_nettype none
module pps_disciplined_timestamp_keeper (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pdtk_item_if.sink     item,
	pdtk_result_if.source result,
	pdtk_cfg_if.sink      cfg
);
	import pdtk_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    res_valid_q;
	result_t res_d;
	cfg_t    cfg_regs;
	logic    advance;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	pdtk_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	pdtk_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.item     (item_s1),
		.cfg_regs (cfg_regs),
		.result   (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.kind           <= item.kind;
			item_s1.unix_ms        <= item.unix_ms;
			item_s1.system_seconds <= item.system_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.timestamp_ms = res_q.timestamp_ms;
	assign result.time_source  = res_q.time_source;
	assign result.synced       = res_q.synced;
	assign result.accepted     = res_q.accepted;

`ifndef ASSERT_OFF
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled input stage lost its item");
	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result register not loaded on advance");
	a_accept_source: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.accepted |-> res_q.time_source != SRC_LOCAL)
		else $error("accepted result reports local source");
`endif
endmodule
`default_nettype wire
